### rtl/hmtp_pkg.sv
`timescale 1ns / 1ps

package hmtp_pkg;

	localparam int COORD_BITS = 16;
	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
	localparam logic [31:0] WHITE_COLOR = 32'h00FF_FFFF;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_HDIG,
		MODE_HSKIP,
		MODE_CHEX,
		MODE_CSKIP
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic [31:0]           hacc;
		logic                  neg;
		logic [31:0]           cacc;
		logic [1:0]            cpos;
		logic                  cseen;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic                  line_text;
	} state_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
		logic signed [31:0]    height;
		logic [31:0]           color;
		logic                  default_color;
	} point_t;

	localparam state_t STATE_RESET = '{
		mode:      MODE_IDLE,
		hacc:      32'd0,
		neg:       1'b0,
		cacc:      32'd0,
		cpos:      2'd0,
		cseen:     1'b0,
		col:       '0,
		row:       '0,
		line_text: 1'b0
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
			((c >= CH_LO_A) && (c <= CH_LO_F));
	endfunction

	// letters a-f / A-F have low nibble 1..6
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (is_digit(c)) begin
			v = c[3:0];
		end else begin
			v = 4'(c[3:0] + 4'd9);
		end
		return v;
	endfunction

	function automatic point_t make_point(input state_t st);
		point_t p;
		p.column        = st.col;
		p.row           = st.row;
		p.height        = st.neg ? $signed(32'(~st.hacc + 32'd1)) : $signed(st.hacc);
		p.color         = st.cseen ? st.cacc : WHITE_COLOR;
		p.default_color = ~st.cseen;
		return p;
	endfunction

endpackage

### rtl/height_map_text_parser.sv
`timescale 1ns / 1ps

// Height-map text parser. Takes one text byte per beat on the input channel and
// gives at most one point per byte on the output channel, with its column, row,
// signed height and color. Each byte is parsed in one combinational pass from
// the token state register, so a byte can be accepted every cycle while the
// output buffer has room; the point from the byte that ends its token is
// registered into a two-entry output buffer, which lets input continue for
// one more point while the output stalls; input waits only when both are full.
module height_map_text_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        ch,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hmtp_pkg::COORD_BITS-1:0]   column,
	output logic [hmtp_pkg::COORD_BITS-1:0]   row,
	output logic signed [31:0]                height,
	output logic [31:0]                       color,
	output logic                              default_color
);

	hmtp_pkg::state_t st_q;
	hmtp_pkg::state_t st_nxt;
	hmtp_pkg::point_t pt;
	hmtp_pkg::point_t head_q;
	hmtp_pkg::point_t spare_q;
	logic             emit;
	logic [1:0]       cnt_q;
	logic             in_fire;
	logic             push;
	logic             pop;

	hmtp_step u_step (
		.st   (st_q),
		.ch   (ch),
		.last (last),
		.nxt  (st_nxt),
		.emit (emit),
		.pt   (pt)
	);

	assign in_ready  = (cnt_q != 2'd2);
	assign in_fire   = in_valid && in_ready;
	assign push      = in_fire && emit;
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= hmtp_pkg::STATE_RESET;
			cnt_q <= 2'd0;
		end else begin
			if (in_fire) begin
				st_q <= st_nxt;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// head entry drives the ports, spare catches a point while the head stalls
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= spare_q;
			end else if (push) begin
				head_q <= pt;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= pt;
			end else begin
				spare_q <= pt;
			end
		end
	end

	assign column        = head_q.column;
	assign row           = head_q.row;
	assign height        = head_q.height;
	assign color         = head_q.color;
	assign default_color = head_q.default_color;

endmodule

### rtl/hmtp_step.sv
`timescale 1ns / 1ps

module hmtp_step (
	input  hmtp_pkg::state_t st,
	input  logic [7:0]       ch,
	input  logic             last,
	output hmtp_pkg::state_t nxt,
	output logic             emit,
	output hmtp_pkg::point_t pt
);

	logic takes;
	hmtp_pkg::state_t nx;

	always_comb begin
		nx    = st;
		takes = 1'b0;
		emit  = 1'b0;
		pt    = hmtp_pkg::make_point(st);

		unique case (st.mode)
			hmtp_pkg::MODE_HDIG: begin
				priority if (hmtp_pkg::is_digit(ch)) begin
					takes   = 1'b1;
					nx.hacc = 32'(st.hacc * 32'd10) + 32'(ch[3:0]);
				end else if (ch == hmtp_pkg::CH_MINUS) begin
					takes   = 1'b1;
					nx.mode = hmtp_pkg::MODE_HSKIP;
				end else if (ch == hmtp_pkg::CH_COMMA) begin
					takes    = 1'b1;
					nx.mode  = hmtp_pkg::MODE_CHEX;
					nx.cseen = 1'b1;
					nx.cacc  = 32'd0;
					nx.cpos  = 2'd0;
				end else begin
					takes = 1'b0;
				end
			end
			hmtp_pkg::MODE_HSKIP: begin
				priority if (hmtp_pkg::is_digit(ch) || ch == hmtp_pkg::CH_MINUS) begin
					takes = 1'b1;
				end else if (ch == hmtp_pkg::CH_COMMA) begin
					takes    = 1'b1;
					nx.mode  = hmtp_pkg::MODE_CHEX;
					nx.cseen = 1'b1;
					nx.cacc  = 32'd0;
					nx.cpos  = 2'd0;
				end else begin
					takes = 1'b0;
				end
			end
			hmtp_pkg::MODE_CHEX: begin
				// x prefix only right after a leading zero
				priority if ((ch == hmtp_pkg::CH_LO_X || ch == hmtp_pkg::CH_UP_X) &&
						st.cpos == 2'd1) begin
					takes   = 1'b1;
					nx.cpos = 2'd2;
				end else if (hmtp_pkg::is_hex(ch)) begin
					takes   = 1'b1;
					nx.cacc = {st.cacc[27:0], hmtp_pkg::hex_val(ch)};
					nx.cpos = (st.cpos == 2'd0 && ch == hmtp_pkg::CH_ZERO) ? 2'd1 : 2'd2;
				end else if (hmtp_pkg::is_alpha(ch)) begin
					takes   = 1'b1;
					nx.mode = hmtp_pkg::MODE_CSKIP;
				end else begin
					takes = 1'b0;
				end
			end
			hmtp_pkg::MODE_CSKIP: begin
				takes = hmtp_pkg::is_digit(ch) || hmtp_pkg::is_alpha(ch);
			end
			default: begin
				takes = 1'b0;
			end
		endcase

		// token ends on a byte it does not take
		if (st.mode != hmtp_pkg::MODE_IDLE && !takes) begin
			emit     = 1'b1;
			pt       = hmtp_pkg::make_point(st);
			nx.col   = (st.col < hmtp_pkg::COORD_MAX) ?
				hmtp_pkg::COORD_BITS'(st.col + 1'b1) : st.col;
			nx.mode  = hmtp_pkg::MODE_IDLE;
			nx.hacc  = 32'd0;
			nx.neg   = 1'b0;
			nx.cacc  = 32'd0;
			nx.cpos  = 2'd0;
			nx.cseen = 1'b0;
		end

		if (nx.mode == hmtp_pkg::MODE_IDLE) begin
			if (ch == hmtp_pkg::CH_MINUS) begin
				nx.mode = hmtp_pkg::MODE_HDIG;
				nx.neg  = 1'b1;
			end else if (hmtp_pkg::is_digit(ch)) begin
				nx.mode = hmtp_pkg::MODE_HDIG;
				nx.hacc = 32'(ch[3:0]);
			end
		end

		if (ch == hmtp_pkg::CH_NL) begin
			if (st.line_text && st.row < hmtp_pkg::COORD_MAX) begin
				nx.row = hmtp_pkg::COORD_BITS'(st.row + 1'b1);
			end
			nx.line_text = 1'b0;
			nx.col       = '0;
		end else begin
			nx.line_text = 1'b1;
		end

		// flush on the final byte unless a point already left on it
		if (last) begin
			if (nx.mode != hmtp_pkg::MODE_IDLE && !emit) begin
				emit = 1'b1;
				pt   = hmtp_pkg::make_point(nx);
			end
			nx = hmtp_pkg::STATE_RESET;
		end

		nxt = nx;
	end

endmodule
